// ----- hdl/wmdc_pkg.sv -----
// Package: shared constants, codes and types for the Wishart classifier.
package wmdc_pkg;

   localparam int MaxClassesDefault = 32;
   localparam int MatrixDimDefault  = 6;
   localparam int FracBitsDefault   = 16;

   localparam int KindWidth  = 2;
   localparam int ClassWidth = 5;
   localparam int EntryWidth = 5;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 6;
   localparam int DistWidth  = 64;
   localparam int QueueDepth = 4;

   typedef enum logic [KindWidth-1:0] {
      KIND_COEF  = 2'd0,
      KIND_BIAS  = 2'd1,
      KIND_PIXEL = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CLASS,
      BK_DONE
   } back_state_type;

   // Command word passed from the front end to the back end.
   typedef struct packed {
      logic                  write_coef;
      logic                  write_bias;
      logic                  write_pixel;
      logic                  classify;
      logic [ClassWidth-1:0] class_index;
      logic [EntryWidth-1:0] entry_index;
      logic [ValueWidth-1:0] value_re;
      logic [ValueWidth-1:0] value_im;
   } cmd_type;

endpackage

// ----- hdl/wmdc_req_if.sv -----
// Interfaces: request and response channels.
interface wmdc_req_if
   import wmdc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [KindWidth-1:0]  kind;
   logic [ClassWidth-1:0] class_index;
   logic [EntryWidth-1:0] entry_index;
   logic signed [ValueWidth-1:0] value_re;
   logic signed [ValueWidth-1:0] value_im;
   logic                  last;
   modport source (output valid, kind, class_index, entry_index, value_re, value_im, last,
                   input ready);
   modport sink   (input valid, kind, class_index, entry_index, value_re, value_im, last,
                   output ready);
endinterface

interface wmdc_rsp_if
   import wmdc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ClassWidth-1:0] best_class;
   logic signed [DistWidth-1:0] best_distance;
   modport source (output valid, best_class, best_distance, input ready);
   modport sink   (input valid, best_class, best_distance, output ready);
endinterface

// ----- hdl/wmdc_front.sv -----
// Front end: decode request words and queue commands for the back end.
module wmdc_front
   import wmdc_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int NumEntries = 21
) (
   input  logic    clock,
   input  logic    reset,
   wmdc_req_if.sink req,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);
   localparam int PtrWidth = $clog2(QueueDepth);

   cmd_type             queue_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   count_ff, count_in;
   cmd_type             decoded;
   logic                push, pop, class_ok, entry_ok;

   // Classify the incoming word
   always_comb begin
      class_ok = 32'(req.class_index) < MaxClasses;
      entry_ok = 32'(req.entry_index) < NumEntries;
      decoded             = '0;
      decoded.class_index = req.class_index;
      decoded.entry_index = req.entry_index;
      decoded.value_re    = req.value_re;
      decoded.value_im    = req.value_im;
      case (kind_type'(req.kind))
         KIND_COEF:  decoded.write_coef = class_ok && entry_ok;
         KIND_BIAS:  decoded.write_bias = class_ok;
         KIND_PIXEL: begin
            decoded.write_pixel = entry_ok;
            decoded.classify    = req.last;
         end
         default:    decoded = decoded;
      endcase
   end

   assign req.ready = count_ff != (PtrWidth+1)'(QueueDepth);
   assign push      = req.valid && req.ready;
   assign cmd_valid = count_ff != '0;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == (PtrWidth+1)'(QueueDepth) |-> !push) else $error("queue overflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("count slip");
   a_empty_no_pop: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !pop) else $error("pop from empty");
endmodule

// ----- hdl/wmdc_back.sv -----
// Back end: coefficient stores and the multiply-accumulate distance search.
module wmdc_back
   import wmdc_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int NumEntries = 21,
   parameter int MatrixDim  = MatrixDimDefault,
   parameter int FracBits   = FracBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CountWidth-1:0] num_classes,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   wmdc_rsp_if.source            rsp
);
   localparam int EntW    = $clog2(NumEntries);
   localparam int ClsW    = $clog2(MaxClasses);
   localparam int AddrW   = $clog2(MaxClasses * NumEntries);
   localparam int AccW    = 72;
   localparam int LimW    = $clog2(MaxClasses + 1);
   localparam int CountMx = (1 << CountWidth) - 1;

   // Entry position tables
   function automatic logic is_diag(input int e);
      int r, c, k;
      logic d;
      k = 0; d = 1'b0;
      for (r = 0; r < MatrixDim; r++) begin
         for (c = r; c < MatrixDim; c++) begin
            if (k == e) d = (r == c);
            k++;
         end
      end
      return d;
   endfunction

   logic [NumEntries-1:0] diag_mask;
   always_comb begin
      for (int i = 0; i < NumEntries; i++) diag_mask[i] = is_diag(i);
   end

   logic [63:0]            coef_mem [MaxClasses*NumEntries];
   logic [ValueWidth-1:0]  bias_mem [MaxClasses];
   logic [63:0]            pix_ff   [NumEntries];
   logic [63:0]            coef_rd_ff;
   logic [ValueWidth-1:0]  bias_rd_ff;

   back_state_type         state_ff, state_in;
   logic [ClsW:0]          cls_ff, cls_in;
   logic [EntW:0]          ent_ff, ent_in;
   logic                   rd_valid_ff, rd_last_ff, rd_first_ff;
   logic [EntW-1:0]        rd_ent_ff;
   logic                   p_valid_ff, p_last_ff, p_first_ff, p_diag_ff;
   logic signed [63:0]     p_re_ff, p_im_ff, p_bias_ff;
   logic [ClsW:0]          rd_cls_ff, p_cls_ff;
   logic signed [AccW-1:0] acc_ff;
   logic                   found_ff;
   logic [ClassWidth-1:0]  best_cls_ff;
   logic signed [63:0]     best_d_ff;
   logic                   out_valid_ff;
   logic [ClassWidth-1:0]  out_cls_ff;
   logic signed [63:0]     out_d_ff;
   logic [LimW-1:0]        limit;
   logic                   issue, cls_end, all_end;
   logic [AddrW-1:0]       rd_addr;
   logic signed [AccW-1:0] acc_sum, sum_term;
   logic signed [63:0]     sat_d;
   logic                   drain_busy;

   // Clamp class count
   always_comb begin
      if (32'(num_classes) > MaxClasses) limit = LimW'(MaxClasses);
      else limit = LimW'(num_classes);
   end

   assign cmd_ready = state_ff == BK_IDLE && !(cmd.classify && out_valid_ff);

   // Store writes
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && cmd_valid && cmd_ready && cmd.write_coef) begin
         coef_mem[AddrW'(32'(cmd.class_index) * NumEntries + 32'(cmd.entry_index))]
            <= {cmd.value_im, cmd.value_re};
      end
      if (state_ff == BK_IDLE && cmd_valid && cmd_ready && cmd.write_bias) begin
         bias_mem[ClsW'(cmd.class_index)] <= cmd.value_re;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumEntries; i++) pix_ff[i] <= '0;
      end else if (cmd_valid && cmd_ready && cmd.write_pixel) begin
         pix_ff[EntW'(cmd.entry_index)] <= {cmd.value_im, cmd.value_re};
      end
   end

   // Sequencer next state
   assign issue   = state_ff == BK_CLASS;
   assign cls_end = ent_ff == (EntW+1)'(NumEntries - 1);
   assign all_end = cls_end && (32'(cls_ff) + 1 >= 32'(limit));
   always_comb begin
      state_in = state_ff;
      cls_in   = cls_ff;
      ent_in   = ent_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd_ready && cmd.classify) begin
               cls_in = (ClsW+1)'(1);
               ent_in = '0;
               state_in = (32'(limit) > 1) ? BK_CLASS : BK_DONE;
            end
         end
         BK_CLASS: begin
            if (cls_end) begin
               ent_in = '0;
               cls_in = cls_ff + 1'b1;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
            if (all_end) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!rd_valid_ff && !p_valid_ff && !drain_busy) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cls_ff   <= '0;
         ent_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cls_ff   <= cls_in;
         ent_ff   <= ent_in;
      end
   end

   // Stage 1: read stores
   assign rd_addr = AddrW'(32'(cls_ff[ClsW-1:0]) * NumEntries + 32'(ent_ff));
   always_ff @(posedge clock) begin
      coef_rd_ff <= coef_mem[rd_addr];
      bias_rd_ff <= bias_mem[cls_ff[ClsW-1:0]];
      rd_ent_ff  <= ent_ff[EntW-1:0];
      rd_cls_ff  <= cls_ff;
      rd_last_ff <= cls_end;
      rd_first_ff <= ent_ff == '0;
   end

   // Stage 2: multiply
   always_ff @(posedge clock) begin
      p_re_ff    <= 64'($signed(coef_rd_ff[31:0])) * 64'($signed(pix_ff[rd_ent_ff][31:0]));
      p_im_ff    <= 64'($signed(coef_rd_ff[63:32])) * 64'($signed(pix_ff[rd_ent_ff][63:32]));
      p_bias_ff  <= 64'($signed(bias_rd_ff)) <<< FracBits;
      p_diag_ff  <= diag_mask[rd_ent_ff];
      p_last_ff  <= rd_last_ff;
      p_first_ff <= rd_first_ff;
      p_cls_ff   <= rd_cls_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         p_valid_ff  <= rd_valid_ff;
      end
   end

   // Stage 3: accumulate and saturate
   always_comb begin
      if (p_diag_ff) sum_term = AccW'(p_re_ff);
      else sum_term = (AccW'(p_re_ff) + AccW'(p_im_ff)) <<< 1;
      acc_sum = (p_first_ff ? AccW'(p_bias_ff) : acc_ff) + sum_term;
      if (acc_sum > AccW'(64'sh7FFF_FFFF_FFFF_FFFF)) sat_d = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (acc_sum < -AccW'(64'sh7FFF_FFFF_FFFF_FFFF) - 1)
         sat_d = 64'sh8000_0000_0000_0000;
      else sat_d = acc_sum[63:0];
   end
   assign drain_busy = out_valid_ff && !rsp.ready;

   always_ff @(posedge clock) begin
      if (p_valid_ff) acc_ff <= acc_sum;
      if (p_valid_ff && p_last_ff && (!found_ff || sat_d < best_d_ff)) begin
         best_d_ff   <= sat_d;
         best_cls_ff <= ClassWidth'(p_cls_ff);
      end else if (state_ff == BK_IDLE) begin
         best_d_ff   <= '0;
         best_cls_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) found_ff <= 1'b0;
      else if (state_ff == BK_IDLE) found_ff <= 1'b0;
      else if (p_valid_ff && p_last_ff) found_ff <= 1'b1;
   end

   // Output register: load when search ends, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == BK_DONE && !rd_valid_ff && !p_valid_ff && !out_valid_ff) begin
         out_valid_ff <= 1'b1;
         out_cls_ff   <= best_cls_ff;
         out_d_ff     <= best_d_ff;
      end else if (out_valid_ff && rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.best_class    = out_cls_ff;
   assign rsp.best_distance = out_d_ff;

   a_idle_no_mac: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_IDLE |-> !issue) else $error("issue while idle");
   a_pipe_follow: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |=> p_valid_ff) else $error("pipeline lost a step");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DONE && state_in == BK_IDLE |=> out_valid_ff) else $error("no result");
   a_limit_ok: assert property (@(posedge clock) disable iff (reset)
      32'(limit) <= MaxClasses && CountMx >= 0) else $error("limit range");
endmodule

// ----- hdl/wishart_min_distance_classify_unit.sv -----
// Top level: Wishart minimum-distance classifier.
//
// The req channel carries words of kind coefficient load, bias load or pixel
// entry; the rsp channel carries one word (best_class, best_distance) per
// pixel entry flagged last. csr_write_enable/csr_write_data set num_classes.
// The user must write it only while the block is idle; it is not enforced.
// Loads and pixel entries are queued in a four-word queue; the back end takes
// them only while it is idle. A classifying word runs one multiply-accumulate
// per coefficient through the shared multiplier pair for each of classes 1 to
// num_classes - 1, num_classes clamped to MaxClasses; the pipeline then drains
// and the result is loaded into the output register.
// Reset clears num_classes to 1, the pixel entries to zero and all control
// state; coefficient and bias stores hold nothing until loaded.
// While rsp stalls the result waits in its output register; loads keep going,
// and a second classification waits until the first result is taken. When
// the queue fills, req.ready drops.
module wishart_min_distance_classify_unit
   import wmdc_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int MatrixDim  = MatrixDimDefault,
   parameter int FracBits   = FracBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   wmdc_req_if.sink              req,
   wmdc_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CountWidth-1:0] csr_write_data
);
   localparam int NumEntries = (MatrixDim * (MatrixDim + 1)) / 2;

   logic [CountWidth-1:0] num_classes_ff;
   logic                  cmd_valid, cmd_ready;
   cmd_type               cmd;

   // Hold class count register
   always_ff @(posedge clock) begin
      if (reset) num_classes_ff <= CountWidth'(1);
      else if (csr_write_enable) num_classes_ff <= csr_write_data;
   end

   wmdc_front #(.MaxClasses(MaxClasses), .NumEntries(NumEntries)) u_front (
      .clock, .reset, .req, .cmd_valid, .cmd_ready, .cmd
   );

   wmdc_back #(.MaxClasses(MaxClasses), .NumEntries(NumEntries),
               .MatrixDim(MatrixDim), .FracBits(FracBits)) u_back (
      .clock, .reset, .num_classes(num_classes_ff), .cmd_valid, .cmd_ready, .cmd, .rsp
   );
endmodule

// ----- test/tb_top.sv -----
// Testbench for the Wishart minimum-distance classifier: loads, pixels, checks.
module tb_top
   import wmdc_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumEntries = 21;
   localparam int NumClasses = 32;
   localparam int HoldCycles = 400;

   typedef struct packed {
      logic [ClassWidth-1:0]      best_class;
      logic signed [DistWidth-1:0] best_distance;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CountWidth-1:0] csr_write_data = '0;

   wmdc_req_if req ();
   wmdc_rsp_if rsp ();

   wishart_min_distance_classify_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // classifier state mirrored by the predictor
   logic [63:0] coef_mem [NumClasses][NumEntries];
   logic [31:0] bias_mem [NumClasses];
   logic [63:0] pixel_mem [NumEntries];
   logic [CountWidth-1:0] class_count;

   result_type expected_results [$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  take_idle_pct = 0;
   int  hold_cycles = 0;
   bit  hold_trigger = 0;
   bit  hold_seen = 0;

   // distance of one class, exact with 128-bit sum then saturated
   function automatic logic signed [63:0] class_distance(int cls);
      logic signed [127:0] sum;
      logic signed [63:0]  re_prod;
      logic signed [63:0]  im_prod;
      int e;
      sum = 128'(signed'(bias_mem[cls])) <<< 16;
      e = 0;
      for (int r = 0; r < 6; r++) begin
         for (int c = r; c < 6; c++) begin
            re_prod = signed'(coef_mem[cls][e][31:0]) * signed'(pixel_mem[e][31:0]);
            sum += 128'(re_prod);
            if (c != r) begin
               im_prod = signed'(coef_mem[cls][e][63:32]) * signed'(pixel_mem[e][63:32]);
               sum += 128'(re_prod) + 2 * 128'(im_prod);
            end
            e++;
         end
      end
      if (sum > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
      if (sum < -128'sh8000000000000000) return 64'sh8000000000000000;
      return sum[63:0];
   endfunction

   // update the mirror for one word; queue a result on a classifying pixel
   task automatic predict_word(kind_type kind, int cls, int ent,
                               logic [31:0] re, logic [31:0] im, bit last);
      result_type res;
      logic signed [63:0] d;
      int limit;
      case (kind)
         KIND_COEF: begin
            if (ent < NumEntries) coef_mem[cls][ent] = {im, re};
         end
         KIND_BIAS: begin
            bias_mem[cls] = re;
         end
         KIND_PIXEL: begin
            if (ent < NumEntries) pixel_mem[ent] = {im, re};
            if (last) begin
               res = '0;
               limit = (class_count > NumClasses) ? NumClasses : class_count;
               for (int k = 1; k < limit; k++) begin
                  d = class_distance(k);
                  if (k == 1 || d < res.best_distance) begin
                     res.best_distance = d;
                     res.best_class = ClassWidth'(k);
                  end
               end
               expected_results.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   // send one word and wait for its acceptance
   task automatic send_word(kind_type kind, int cls, int ent,
                            logic [31:0] re, logic [31:0] im, bit last);
      logic [ClassWidth-1:0] cls_word;
      logic [EntryWidth-1:0] ent_word;
      cls_word = ClassWidth'(cls);
      ent_word = EntryWidth'(ent);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.kind        <= kind;
      req.class_index <= cls_word;
      req.entry_index <= ent_word;
      req.value_re    <= re;
      req.value_im    <= im;
      req.last        <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_word(kind, int'(cls_word), int'(ent_word), re, im, last);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(255) - 128;
         default: return $urandom;
      endcase
   endfunction

   // wait until all results are in, then let trailing work finish
   task automatic drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= CountWidth'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      class_count = CountWidth'(value);
   endtask

   task automatic load_class(int cls, bit extreme);
      for (int e = 0; e < NumEntries; e++)
         send_word(KIND_COEF, cls, e, extreme ? 32'h80000000 : rand_value(),
                   extreme ? 32'h7FFFFFFF : rand_value(), $urandom_range(1));
      send_word(KIND_BIAS, cls, $urandom_range(31),
                extreme ? 32'h7FFFFFFF : rand_value(), $urandom, 0);
   endtask

   task automatic send_pixel(int entries);
      for (int e = 0; e < entries; e++)
         send_word(KIND_PIXEL, $urandom_range(31), $urandom_range(20),
                   rand_value(), rand_value(), 0);
      send_word(KIND_PIXEL, $urandom_range(31), $urandom_range(31),
                rand_value(), rand_value(), 1);
   endtask

   // directed: no classes, full-scale loads, ignored words, ties
   task automatic test_directed();
      send_word(KIND_PIXEL, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1);
      write_count(0);
      send_word(KIND_PIXEL, 31, 31, 32'h80000000, 32'h7FFFFFFF, 1);
      load_class(1, 1);
      load_class(2, 1);
      load_class(3, 0);
      write_count(4);
      for (int e = 0; e < NumEntries; e++)
         send_word(KIND_PIXEL, 0, e, 32'h80000000, 32'h80000000, 0);
      send_word(KIND_PIXEL, 0, 20, 32'h80000000, 32'h7FFFFFFF, 1);
      send_word(KIND_NONE, 5, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
      send_word(KIND_COEF, 1, 25, 32'h12345678, 32'h9ABCDEF0, 1);
      send_word(KIND_PIXEL, 0, 22, 32'h0, 32'h0, 1);
   endtask

   // load every class with random coefficients and bias
   task automatic test_load_all();
      for (int c = 0; c < NumClasses; c++) load_class(c, 0);
   endtask

   // random: pixels under several class counts
   task automatic test_random();
      int counts [5] = '{32, 63, 2, 17, 40};
      foreach (counts[i]) begin
         write_count(counts[i]);
         for (int p = 0; p < 2; p++) begin
            if ($urandom_range(9) == 0) load_class($urandom_range(31), 0);
            else if ($urandom_range(9) == 0)
               send_word(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_pixel($urandom_range(20));
         end
      end
      write_count(3);
      for (int p = 0; p < 10; p++) send_pixel($urandom_range(3));
   endtask

   // long receiver hold-off while words keep coming
   task automatic test_backpressure();
      hold_trigger <= !hold_trigger;
      for (int p = 0; p < 8; p++) send_pixel(0);
   endtask

   // receiver side
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen   <= hold_trigger;
         hold_cycles <= HoldCycles;
         rsp.ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result class %0d dist %0d", $realtime,
                     rsp.best_class, rsp.best_distance);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (exp_res.best_class !== rsp.best_class) begin
               $display("%0t best_class expected %0d actual %0d", $realtime,
                        exp_res.best_class, rsp.best_class);
               error_count++;
            end
            if (exp_res.best_distance !== rsp.best_distance) begin
               $display("%0t best_distance expected %0d actual %0d", $realtime,
                        exp_res.best_distance, rsp.best_distance);
               error_count++;
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_NONE;
      req.class_index = '0;
      req.entry_index = '0;
      req.value_re = '0;
      req.value_im = '0;
      req.last = 1'b0;
      class_count = 1;
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 31;
      take_idle_pct = 76;
      test_directed();
      test_load_all();
      test_random();
      send_idle_pct = 76;
      take_idle_pct = 31;
      test_random();
      send_idle_pct = 0;
      take_idle_pct = 0;
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0 && expected_results.size() == 0)
         $display("[wishart_min_distance_classify_unit] OK");
      else
         $display("[wishart_min_distance_classify_unit] ERROR");
      $finish;
   end

   // hold a hard limit on run time
   initial begin
      #20ms;
      $display("[wishart_min_distance_classify_unit] ERROR");
      $finish;
   end
endmodule

// ----- wishart_min_distance_classify_unit.f -----
hdl/wmdc_pkg.sv
hdl/wmdc_req_if.sv
hdl/wmdc_front.sv
hdl/wmdc_back.sv
hdl/wishart_min_distance_classify_unit.sv
test/tb_top.sv
